// File: src/bale_pkg.sv
`default_nettype none

package bale_pkg;

    // operation codes on s_kind
    localparam logic [1:0] KIND_INSERT = 2'd0;
    localparam logic [1:0] KIND_DELETE = 2'd1;
    localparam logic [1:0] KIND_READ   = 2'd2;

    // status codes on m_status
    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;
    localparam logic [1:0] ST_RANGE = 2'd3;

    typedef enum logic [1:0] {
        SEQ_IDLE,
        SEQ_READ,
        SEQ_SHIFT,
        SEQ_PLACE
    } bale_state_t;

    typedef struct packed {
        logic        [1:0]  status;
        logic signed [31:0] read_word;
        logic        [7:0]  entry_count;
    } bale_res_t;

endpackage

`default_nettype wire

// File: src/bale_mem.sv
`default_nettype none

module bale_mem #(
    parameter int DEPTH = 128,
    parameter int WIDTH = 32,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// File: src/bale_seq.sv
`default_nettype none

module bale_seq #(
    parameter int CAPACITY  = 128,
    parameter int WORD_BITS = 32,
    parameter int AW        = $clog2(CAPACITY),
    parameter int CW        = $clog2(CAPACITY + 1)
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic [1:0]            kind,
    input  wire logic signed [31:0]    value,
    input  wire logic [7:0]            position,
    input  wire logic                  out_free,
    output logic                       res_valid,
    output bale_pkg::bale_res_t        res,
    output logic                       mem_we,
    output logic [AW-1:0]              mem_waddr,
    output logic [WORD_BITS-1:0]       mem_wdata,
    output logic [AW-1:0]              mem_raddr,
    input  wire logic [WORD_BITS-1:0]  mem_rdata
);

    localparam int CMPW = (CW > 8) ? CW : 8;

    bale_pkg::bale_state_t state_reg, state_next;
    logic [CW-1:0]        count_reg, count_next;
    logic [AW-1:0]        wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]        pos_reg, pos_next;
    logic [WORD_BITS-1:0] val_reg, val_next;

    logic [CMPW-1:0]             pos_x;
    logic [CMPW-1:0]             cnt_x;
    logic signed [WORD_BITS-1:0] rd_s;
    logic [WORD_BITS-1:0]        val_in;
    logic                        take;

    assign pos_x  = CMPW'(position);
    assign cnt_x  = CMPW'(count_reg);
    assign rd_s   = mem_rdata;
    assign val_in = WORD_BITS'(value);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= bale_pkg::SEQ_IDLE;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        wr_ptr_reg <= wr_ptr_next;
        pos_reg    <= pos_next;
        val_reg    <= val_next;
    end

    always_comb begin
        state_next  = state_reg;
        count_next  = count_reg;
        wr_ptr_next = wr_ptr_reg;
        pos_next    = pos_reg;
        val_next    = val_reg;
        in_ready    = (state_reg == bale_pkg::SEQ_IDLE) && out_free;
        take        = in_valid && in_ready;
        mem_we      = 1'b0;
        mem_waddr   = '0;
        mem_wdata   = '0;
        mem_raddr   = AW'(position);
        res_valid   = 1'b0;
        res.status      = bale_pkg::ST_DONE;
        res.read_word   = '0;
        res.entry_count = 8'(count_reg);

        unique case (state_reg)
            bale_pkg::SEQ_IDLE: begin
                if (take) begin
                    case (kind)
                        bale_pkg::KIND_INSERT: begin
                            if (count_reg == CW'(CAPACITY)) begin
                                res_valid  = 1'b1;
                                res.status = bale_pkg::ST_FULL;
                            end else if (pos_x > cnt_x) begin
                                res_valid  = 1'b1;
                                res.status = bale_pkg::ST_RANGE;
                            end else if (pos_x == cnt_x) begin
                                // append: nothing to move
                                mem_we          = 1'b1;
                                mem_waddr       = AW'(position);
                                mem_wdata       = val_in;
                                count_next      = CW'(count_reg + 1'b1);
                                res_valid       = 1'b1;
                                res.entry_count = 8'(count_next);
                            end else begin
                                mem_raddr   = AW'(count_reg - 1'b1);
                                wr_ptr_next = AW'(count_reg);
                                pos_next    = AW'(position);
                                val_next    = val_in;
                                state_next  = bale_pkg::SEQ_SHIFT;
                            end
                        end
                        bale_pkg::KIND_DELETE: begin
                            res_valid = 1'b1;
                            if (count_reg == '0) begin
                                res.status = bale_pkg::ST_EMPTY;
                            end else begin
                                count_next      = CW'(count_reg - 1'b1);
                                res.entry_count = 8'(count_next);
                            end
                        end
                        bale_pkg::KIND_READ: begin
                            if (count_reg == '0) begin
                                res_valid  = 1'b1;
                                res.status = bale_pkg::ST_EMPTY;
                            end else if (pos_x >= cnt_x) begin
                                res_valid  = 1'b1;
                                res.status = bale_pkg::ST_RANGE;
                            end else begin
                                state_next = bale_pkg::SEQ_READ;
                            end
                        end
                        default: begin
                            res_valid = 1'b1;
                        end
                    endcase
                end
            end
            bale_pkg::SEQ_READ: begin
                res_valid     = 1'b1;
                res.read_word = 32'(rd_s);
                state_next    = bale_pkg::SEQ_IDLE;
            end
            bale_pkg::SEQ_SHIFT: begin
                // write the word fetched last cycle one slot up, fetch the next one down
                mem_we    = 1'b1;
                mem_waddr = wr_ptr_reg;
                mem_wdata = mem_rdata;
                if (wr_ptr_reg == AW'(pos_reg + AW'(1))) begin
                    state_next = bale_pkg::SEQ_PLACE;
                end else begin
                    mem_raddr   = AW'(wr_ptr_reg - AW'(2));
                    wr_ptr_next = AW'(wr_ptr_reg - AW'(1));
                end
            end
            bale_pkg::SEQ_PLACE: begin
                mem_we          = 1'b1;
                mem_waddr       = pos_reg;
                mem_wdata       = val_reg;
                count_next      = CW'(count_reg + 1'b1);
                res_valid       = 1'b1;
                res.entry_count = 8'(count_next);
                state_next      = bale_pkg::SEQ_IDLE;
            end
            default: begin
                state_next = bale_pkg::SEQ_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: src/bounded_array_list_engine.sv
//  channel | ports                                       | direction
//  s_      | s_valid s_ready s_kind s_value s_position   | operation item in
//  m_      | m_valid m_ready m_status m_read_word         | result item out
//          | m_entry_count                               |
//
//  Rejected operations, delete, append (insert at count) and unused kinds
//  answer straight from the idle state. Read waits in the read state for the
//  registered read of the list memory. Insert below count moves one entry
//  per cycle through the single memory write port, then places the value.
//  Reset (aresetn low, synchronous) empties the list; memory contents are not
//  cleared. A result waits in the output register; the next item is taken
//  once that register is empty or being drained the same cycle.
`default_nettype none

module bounded_array_list_engine #(
    parameter int CAPACITY  = 128,
    parameter int WORD_BITS = 32
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [1:0]         s_kind,
    input  wire logic signed [31:0] s_value,
    input  wire logic [7:0]         s_position,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [1:0]              m_status,
    output logic signed [31:0]      m_read_word,
    output logic [7:0]              m_entry_count
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    logic                   out_free;
    logic                   res_valid;
    bale_pkg::bale_res_t    res;
    bale_pkg::bale_res_t    res_reg;
    logic                   m_valid_reg;

    logic                   mem_we;
    logic [AW-1:0]          mem_waddr;
    logic [WORD_BITS-1:0]   mem_wdata;
    logic [AW-1:0]          mem_raddr;
    logic [WORD_BITS-1:0]   mem_rdata;

    // output register frees the sequencer once it is empty or its result is being taken
    assign out_free = !m_valid_reg || m_ready;

    bale_seq #(
        .CAPACITY  (CAPACITY),
        .WORD_BITS (WORD_BITS),
        .AW        (AW),
        .CW        (CW)
    ) u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .kind      (s_kind),
        .value     (s_value),
        .position  (s_position),
        .out_free  (out_free),
        .res_valid (res_valid),
        .res       (res),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    // list storage: one write and one registered read per cycle
    bale_mem #(
        .DEPTH (CAPACITY),
        .WIDTH (WORD_BITS),
        .AW    (AW)
    ) u_mem (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_valid) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid) begin
            res_reg <= res;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_status      = res_reg.status;
    assign m_read_word   = res_reg.read_word;
    assign m_entry_count = res_reg.entry_count;

`ifndef SYNTHESIS
    // a held result blocks new items
    a_hold_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |-> !s_ready)
        else $error("item accepted while result stalled");

    // only a successful read carries a word
    a_word_only_on_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status != bale_pkg::ST_DONE) |-> m_read_word == 32'sd0)
        else $error("nonzero word on failed operation");

    // list full is reported only at capacity
    a_full_at_capacity: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == bale_pkg::ST_FULL) |-> m_entry_count == 8'(CAPACITY))
        else $error("full status below capacity");

    // a new result is never loaded over one that was not taken
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_entry_count))
        else $error("pending result lost");
`endif

endmodule

`default_nettype wire

// File: dv/bounded_array_list_engine_tb.sv
`timescale 1ns / 1ps

module bounded_array_list_engine_tb;

    localparam int         LIST_CAP    = 128;
    localparam logic [1:0] KIND_UNUSED = 2'd3;
    // worst insert at the front of a nearly full list, plus margin
    localparam int         DRAIN_WAIT  = LIST_CAP + 16;

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic [1:0]         s_kind;
    logic signed [31:0] s_value;
    logic [7:0]         s_position;
    logic               m_valid;
    logic               m_ready;
    logic [1:0]         m_status;
    logic signed [31:0] m_read_word;
    logic [7:0]         m_entry_count;

    // shadow copy of the list, updated when an item is accepted
    logic signed [31:0] list_words [0:LIST_CAP-1];
    int                 list_len;

    // predicted results, oldest first
    bale_pkg::bale_res_t pending_results [$];

    bit                 idle_on;
    int                 error_count;
    int                 op_count;
    int                 result_count;
    int                 status_hits [4];
    int                 kind_hits [4];

    bounded_array_list_engine DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_kind        (s_kind),
        .s_value       (s_value),
        .s_position    (s_position),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_read_word   (m_read_word),
        .m_entry_count (m_entry_count)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Safety net: far beyond the slowest legal run (every insert shifting a
    // near-full list while both sides stall as long as they can).
    initial begin
        #8_000_000;
        $display("bounded_array_list_engine test failed");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        error_count++;
        $display("[%0t] MISMATCH: %s", $realtime, msg);
    endtask

    // Apply one operation to the shadow list and return the result item
    // the block should produce for it.
    function automatic bale_pkg::bale_res_t apply_list_op(input logic [1:0] kind,
                                                          input logic signed [31:0] value,
                                                          input logic [7:0] pos);
        bale_pkg::bale_res_t res;
        int                  i;
        res.status    = bale_pkg::ST_DONE;
        res.read_word = '0;
        case (kind)
            bale_pkg::KIND_INSERT: begin
                // full takes precedence over a bad position
                if (list_len >= LIST_CAP) begin
                    res.status = bale_pkg::ST_FULL;
                end else if (int'(pos) > list_len) begin
                    res.status = bale_pkg::ST_RANGE;
                end else begin
                    for (i = list_len; i > int'(pos); i--)
                        list_words[i] = list_words[i-1];
                    list_words[pos] = value;
                    list_len++;
                end
            end
            bale_pkg::KIND_DELETE: begin
                if (list_len == 0) begin
                    res.status = bale_pkg::ST_EMPTY;
                end else begin
                    list_words[list_len-1] = '0;
                    list_len--;
                end
            end
            bale_pkg::KIND_READ: begin
                if (list_len == 0) begin
                    res.status = bale_pkg::ST_EMPTY;
                end else if (int'(pos) >= list_len) begin
                    res.status = bale_pkg::ST_RANGE;
                end else begin
                    res.read_word = list_words[pos];
                end
            end
            default: ; // unused kind: no effect, status done
        endcase
        res.entry_count = list_len[7:0];
        return res;
    endfunction

    // Present one item; optionally idle first. Returns just after the
    // rising edge that accepted it. Valid stays high between items that
    // follow each other without a gap.
    task automatic send_op(input logic [1:0] kind, input logic signed [31:0] value,
                           input logic [7:0] pos);
        bale_pkg::bale_res_t res;
        int                  gap;
        if (idle_on && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 9);
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_valid    <= 1'b1;
        s_kind     <= kind;
        s_value    <= value;
        s_position <= pos;
        do @(posedge aclk); while (!(s_valid && s_ready));
        res = apply_list_op(kind, value, pos);
        pending_results.push_back(res);
        op_count++;
        kind_hits[kind]++;
        status_hits[res.status]++;
    endtask

    // Drop valid and hold off until every outstanding result has come back.
    task automatic wait_for_results();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    function automatic logic signed [31:0] pick_word();
        case ($urandom_range(0, 11))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7FFF_FFFF;
            2:       return 32'sh0000_0000;
            3:       return -32'sd1;
            default: return $urandom;
        endcase
    endfunction

    // One random operation shaped by the current fill level. Growing mode
    // leans toward inserts so the list reaches full; shrinking leans toward
    // deletes so it reaches empty.
    task automatic random_op(input bit grow);
        int         roll;
        int         ins_cut;
        int         del_cut;
        logic [7:0] pos;
        roll    = $urandom_range(0, 99);
        ins_cut = grow ? 55 : 25;
        del_cut = ins_cut + (grow ? 10 : 40);
        pos     = 8'($urandom_range(0, 255));
        if (roll < ins_cut) begin
            if ($urandom_range(0, 9) == 0 && list_len < 255)
                pos = 8'($urandom_range(list_len + 1, 255));
            else if ($urandom_range(0, 3) == 0)
                pos = ($urandom_range(0, 1) == 0) ? 8'd0 : list_len[7:0];
            else
                pos = 8'($urandom_range(0, list_len));
            send_op(bale_pkg::KIND_INSERT, pick_word(), pos);
        end else if (roll < del_cut) begin
            send_op(bale_pkg::KIND_DELETE, $urandom, pos);
        end else if (roll < 95) begin
            if (list_len > 0) begin
                if ($urandom_range(0, 9) == 0)
                    pos = 8'($urandom_range(list_len, 255));
                else
                    pos = 8'($urandom_range(0, list_len - 1));
            end
            send_op(bale_pkg::KIND_READ, $urandom, pos);
        end else begin
            send_op(KIND_UNUSED, $urandom, pos);
        end
    endtask

    // Corner cases on a short list: empty-list errors, extreme words,
    // front/middle/back inserts, reads on and past the top, unused kind.
    task automatic test_short_list();
        int i;
        send_op(bale_pkg::KIND_DELETE, 32'sd0, 8'd0);
        send_op(bale_pkg::KIND_READ, 32'sd0, 8'd0);
        send_op(bale_pkg::KIND_INSERT, 32'sd5, 8'd1);
        send_op(KIND_UNUSED, 32'sh7FFF_FFFF, 8'd255);
        send_op(bale_pkg::KIND_INSERT, 32'sh8000_0000, 8'd0);
        send_op(bale_pkg::KIND_INSERT, 32'sh7FFF_FFFF, 8'd1);
        send_op(bale_pkg::KIND_INSERT, 32'sh0000_0000, 8'd0);
        send_op(bale_pkg::KIND_INSERT, -32'sd1, 8'd1);
        send_op(bale_pkg::KIND_INSERT, 32'sh5555_5555, 8'd4);
        send_op(bale_pkg::KIND_INSERT, 32'shAAAA_AAAA, 8'd2);
        for (i = 0; i < 6; i++)
            send_op(bale_pkg::KIND_READ, $urandom, i[7:0]);
        send_op(bale_pkg::KIND_READ, 32'sd0, 8'd6);
        send_op(bale_pkg::KIND_READ, 32'sd0, 8'd128);
        send_op(bale_pkg::KIND_INSERT, 32'sd9, 8'd7);
        send_op(bale_pkg::KIND_INSERT, 32'sd9, 8'd255);
        send_op(bale_pkg::KIND_DELETE, 32'sh1234_5678, 8'd3);
        send_op(bale_pkg::KIND_READ, 32'sd0, 8'd5);
        send_op(bale_pkg::KIND_READ, 32'sd0, 8'd4);
    endtask

    // Fill to capacity through random positions, then hit the full list.
    task automatic test_fill_to_capacity();
        while (list_len < LIST_CAP)
            send_op(bale_pkg::KIND_INSERT, pick_word(), 8'($urandom_range(0, list_len)));
        send_op(bale_pkg::KIND_INSERT, 32'sd1, 8'd0);
        send_op(bale_pkg::KIND_INSERT, 32'sd1, 8'd128);
        send_op(bale_pkg::KIND_INSERT, 32'sd1, 8'd255);
        send_op(bale_pkg::KIND_READ, 32'sd0, 8'd127);
        send_op(bale_pkg::KIND_READ, 32'sd0, 8'd0);
        send_op(bale_pkg::KIND_READ, 32'sd0, 8'd128);
        send_op(bale_pkg::KIND_READ, 32'sd0, 8'd255);
        // sender holds off until the block has answered everything
        wait_for_results();
        send_op(bale_pkg::KIND_DELETE, 32'sd0, 8'd0);
        send_op(bale_pkg::KIND_INSERT, 32'sh7FFF_FFFF, 8'd127);
        send_op(bale_pkg::KIND_READ, 32'sd0, 8'd127);
    endtask

    // Long random mix; grow and shrink phases alternate so the list swings
    // between the two ends.
    task automatic test_random_mix();
        int  n;
        bit  grow;
        grow = 1'b0;
        for (n = 0; n < 400; n++) begin
            if (n % 50 == 0)
                grow = ~grow;
            random_op(grow);
        end
    endtask

    // Take the list down to empty with reads in between, then the empty
    // list errors once more.
    task automatic test_drain_to_empty();
        while (list_len > 0) begin
            if ($urandom_range(0, 2) == 0)
                send_op(bale_pkg::KIND_READ, $urandom,
                        8'($urandom_range(0, list_len - 1)));
            send_op(bale_pkg::KIND_DELETE, $urandom, 8'($urandom_range(0, 255)));
        end
        send_op(bale_pkg::KIND_DELETE, 32'sd0, 8'd0);
        send_op(bale_pkg::KIND_READ, 32'sd0, 8'd0);
        send_op(bale_pkg::KIND_INSERT, 32'sd3, 8'd1);
    endtask

    // Final stretch with both sides always ready.
    task automatic test_back_to_back();
        int n;
        idle_on = 1'b0;
        for (n = 0; n < 80; n++)
            random_op(n < 50);
    endtask

    // Result channel: random stall bursts while idling is on.
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (idle_on && aresetn && $urandom_range(0, 5) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 9) - 1) @(negedge aclk);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Every accepted result is matched against the oldest prediction.
    always @(posedge aclk) begin : check_results
        bale_pkg::bale_res_t want;
        if (aresetn && m_valid && m_ready) begin
            result_count++;
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result status=%0d word=%0d count=%0d",
                                          m_status, m_read_word, m_entry_count));
            end else begin
                want = pending_results.pop_front();
                if (m_status !== want.status)
                    report_mismatch($sformatf("result %0d status %0d, want %0d",
                                              result_count, m_status, want.status));
                if (m_read_word !== want.read_word)
                    report_mismatch($sformatf("result %0d read_word %0d, want %0d",
                                              result_count, m_read_word, want.read_word));
                if (m_entry_count !== want.entry_count)
                    report_mismatch($sformatf("result %0d entry_count %0d, want %0d",
                                              result_count, m_entry_count,
                                              want.entry_count));
            end
        end
    end

    initial begin
        int i;
        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_kind      = bale_pkg::KIND_INSERT;
        s_value     = '0;
        s_position  = '0;
        idle_on     = 1'b1;
        error_count = 0;
        op_count    = 0;
        result_count = 0;
        list_len    = 0;
        for (i = 0; i < 4; i++) begin
            status_hits[i] = 0;
            kind_hits[i]   = 0;
        end
        for (i = 0; i < LIST_CAP; i++)
            list_words[i] = '0;

        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_short_list();
        test_fill_to_capacity();
        test_random_mix();
        test_drain_to_empty();
        test_back_to_back();

        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        // room for a stray late result to show up
        repeat (DRAIN_WAIT) @(posedge aclk);

        $display("Ran %0d operations (%0d insert, %0d delete, %0d read, %0d unused kind)",
                 op_count, kind_hits[bale_pkg::KIND_INSERT], kind_hits[bale_pkg::KIND_DELETE],
                 kind_hits[bale_pkg::KIND_READ], kind_hits[KIND_UNUSED]);
        $display("Outcomes: %0d done, %0d full, %0d empty, %0d out of range; %0d errors",
                 status_hits[bale_pkg::ST_DONE], status_hits[bale_pkg::ST_FULL],
                 status_hits[bale_pkg::ST_EMPTY], status_hits[bale_pkg::ST_RANGE],
                 error_count);
        if (error_count == 0) begin
            $display("bounded_array_list_engine test passed");
        end else begin
            $display("bounded_array_list_engine test failed");
        end
        $finish;
    end

endmodule
